>>> rtl/knn_pkg.sv
// Shared types and constants for the k-nearest-neighbour mask block.
// Depends on nothing; every other file but knn_ram refers to it by scoped names.
package knn_pkg;

    // Field widths fixed by the stream and register definitions.
    localparam int COL_W      = 6;
    localparam int ROW_W      = 6;
    localparam int CNT_W      = 7;
    localparam int IN_DIST_W  = 32;
    localparam int MASK_W     = 64;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register word index, taken from paddr[2].
    localparam logic REG_NEIGHBOR_COUNT = 1'b0;
    localparam logic REG_NODE_COUNT     = 1'b1;

    // Register reset values.
    localparam logic [CNT_W-1:0] NEIGHBOR_COUNT_RST = 7'd8;
    localparam logic [CNT_W-1:0] NODE_COUNT_RST     = 7'd64;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SWEEP  = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             wr_en;      // store the accepted distance
        logic             close;      // row closes: clear ranks, latch row
        logic             rd_en;      // broadcast read of one stored distance
        logic [COL_W-1:0] rd_addr;
        logic             load_out;   // capture row and mask into the output
    } t_dp_cmd;

endpackage

>>> rtl/knn_if.sv
// Stream interfaces for distance beats in and neighbour mask beats out.
// Depends on knn_pkg for the field widths.
interface knn_in_if;
    logic                           valid;
    logic                           ready;
    logic [knn_pkg::ROW_W-1:0]      row_index;
    logic [knn_pkg::COL_W-1:0]      column_index;
    logic [knn_pkg::IN_DIST_W-1:0]  distance;

    modport source (output valid, row_index, column_index, distance, input ready);
    modport sink   (input valid, row_index, column_index, distance, output ready);
endinterface

interface knn_out_if;
    logic                       valid;
    logic                       ready;
    logic [knn_pkg::ROW_W-1:0]  result_row;
    logic [knn_pkg::MASK_W-1:0] neighbor_mask;

    modport source (output valid, result_row, neighbor_mask, input ready);
    modport sink   (input valid, result_row, neighbor_mask, output ready);
endinterface

>>> rtl/knn_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module knn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/knn_cfg.sv
// APB register file holding the neighbour count and the node count.
// Depends on knn_pkg for register indexes, widths and reset values.
module knn_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic [knn_pkg::APB_ADDR_W-1:0]     i_paddr,
    input  logic [knn_pkg::APB_DATA_W-1:0]     i_pwdata,
    output logic [knn_pkg::APB_DATA_W-1:0]     o_prdata,
    output logic                               o_pready,
    output logic [knn_pkg::CNT_W-1:0]          o_neighbor_count,
    output logic [knn_pkg::CNT_W-1:0]          o_node_count
);

    logic [knn_pkg::CNT_W-1:0] r_neighbor_count;
    logic [knn_pkg::CNT_W-1:0] n_neighbor_count;
    logic [knn_pkg::CNT_W-1:0] r_node_count;
    logic [knn_pkg::CNT_W-1:0] n_node_count;
    logic                      w_wr;

    // pready is tied high, so every access phase completes without wait states.
    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    // Write decode on the word address.
    always_comb begin
        n_neighbor_count = r_neighbor_count;
        n_node_count     = r_node_count;
        if (w_wr) begin
            unique case (i_paddr[2])
                knn_pkg::REG_NEIGHBOR_COUNT: n_neighbor_count = i_pwdata[knn_pkg::CNT_W-1:0];
                knn_pkg::REG_NODE_COUNT:     n_node_count     = i_pwdata[knn_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neighbor_count <= knn_pkg::NEIGHBOR_COUNT_RST;
            r_node_count     <= knn_pkg::NODE_COUNT_RST;
        end else begin
            r_neighbor_count <= n_neighbor_count;
            r_node_count     <= n_node_count;
        end
    end

    // Read decode.
    always_comb begin
        unique case (i_paddr[2])
            knn_pkg::REG_NEIGHBOR_COUNT: o_prdata = knn_pkg::APB_DATA_W'(r_neighbor_count);
            knn_pkg::REG_NODE_COUNT:     o_prdata = knn_pkg::APB_DATA_W'(r_node_count);
            default:                     o_prdata = '0;
        endcase
    end

    assign o_neighbor_count = r_neighbor_count;
    assign o_node_count     = r_node_count;

endmodule

>>> rtl/knn_ctrl.sv
// Controller: accepts distance beats, runs the ranking sweep when a row
// closes and hands the result to the output register. Depends on knn_pkg.
module knn_ctrl #(
    parameter int MAX_NODES = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [knn_pkg::COL_W-1:0]  i_col,
    input  logic [knn_pkg::CNT_W-1:0]  i_nodes,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output knn_pkg::t_dp_cmd           o_cmd
);

    knn_pkg::t_state           r_state;
    knn_pkg::t_state           n_state;
    logic [knn_pkg::COL_W-1:0] r_addr;
    logic [knn_pkg::COL_W-1:0] n_addr;
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic                      w_accept;
    logic                      w_col_ok;
    logic                      w_close;
    logic                      w_last;
    logic [knn_pkg::CNT_W-1:0] w_last_col;

    assign w_last_col = i_nodes - knn_pkg::CNT_W'(1);
    assign o_in_ready = (r_state == knn_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_col_ok   = {1'b0, i_col} < knn_pkg::CNT_W'(MAX_NODES);
    assign w_close    = w_accept && ({1'b0, i_col} == w_last_col);
    assign w_last     = ({1'b0, r_addr} == w_last_col);

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        n_addr         = r_addr;
        o_cmd          = '0;
        o_cmd.wr_en    = w_accept && w_col_ok;
        o_cmd.close    = w_close;
        o_cmd.rd_addr  = r_addr;
        unique case (r_state)
            knn_pkg::ST_IDLE: begin
                if (w_close) begin
                    n_addr  = '0;
                    n_state = knn_pkg::ST_SWEEP;
                end
            end
            knn_pkg::ST_SWEEP: begin
                o_cmd.rd_en = 1'b1;
                if (w_last) begin
                    n_state = knn_pkg::ST_DRAIN;
                end else begin
                    n_addr = r_addr + knn_pkg::COL_W'(1);
                end
            end
            knn_pkg::ST_DRAIN: begin
                // The last broadcast distance is compared in this cycle.
                n_state = knn_pkg::ST_FINISH;
            end
            knn_pkg::ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = knn_pkg::ST_IDLE;
                end
            end
            default: n_state = knn_pkg::ST_IDLE;
        endcase
    end

    // Output register valid flag.
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= knn_pkg::ST_IDLE;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/knn_dpath.sv
// Datapath: distance RAM, a row of compare cells with rank counters and
// the output register. Depends on knn_pkg and knn_ram.
module knn_dpath #(
    parameter int MAX_NODES  = 64,
    parameter int DIST_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  knn_pkg::t_dp_cmd              i_cmd,
    input  logic [knn_pkg::ROW_W-1:0]     i_row,
    input  logic [knn_pkg::COL_W-1:0]     i_col,
    input  logic [knn_pkg::IN_DIST_W-1:0] i_dist,
    input  logic [knn_pkg::CNT_W-1:0]     i_neighbors,
    input  logic [knn_pkg::CNT_W-1:0]     i_nodes,
    output logic [knn_pkg::ROW_W-1:0]     o_result_row,
    output logic [knn_pkg::MASK_W-1:0]    o_neighbor_mask
);

    localparam int IDX_W = $clog2(MAX_NODES);

    logic [DIST_WIDTH-1:0]         w_dist;
    logic [DIST_WIDTH-1:0]         w_bc_dist;
    logic                          r_bc_valid;
    logic [IDX_W-1:0]              r_bc_idx;
    logic [DIST_WIDTH-1:0]         r_cell_dist [MAX_NODES];
    logic [knn_pkg::COL_W-1:0]     r_rank      [MAX_NODES];
    logic [knn_pkg::ROW_W-1:0]     r_close_row;
    logic [knn_pkg::ROW_W-1:0]     r_out_row;
    logic [knn_pkg::MASK_W-1:0]    r_out_mask;
    logic [knn_pkg::MASK_W-1:0]    w_mask;
    logic [knn_pkg::CNT_W-1:0]     w_k;

    // Distances are kept at the configured precision.
    assign w_dist = DIST_WIDTH'(i_dist);

    // Distance store, read once per sweep step for the broadcast.
    knn_ram #(
        .WIDTH (DIST_WIDTH),
        .DEPTH (MAX_NODES)
    ) u_dist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_col[IDX_W-1:0]),
        .i_wr_data (w_dist),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_cmd.rd_addr[IDX_W-1:0]),
        .o_rd_data (w_bc_dist)
    );

    // The broadcast valid flag and index are registered alongside the RAM read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc_valid <= 1'b0;
        end else begin
            r_bc_valid <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bc_idx <= i_cmd.rd_addr[IDX_W-1:0];
    end

    // Each cell keeps its own distance copy and counts the entries that
    // rank ahead of it; equal distances go to the lower column.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_NODES; j++) begin
            if (i_cmd.wr_en && (i_col == knn_pkg::COL_W'(j))) begin
                r_cell_dist[j] <= w_dist;
            end
            if (i_cmd.close) begin
                r_rank[j] <= '0;
            end else if (r_bc_valid &&
                         ((w_bc_dist < r_cell_dist[j]) ||
                          ((w_bc_dist == r_cell_dist[j]) && (r_bc_idx < IDX_W'(j))))) begin
                r_rank[j] <= r_rank[j] + knn_pkg::COL_W'(1);
            end
        end
    end

    // A column is marked when it is in use and its rank is below k.
    assign w_k = (i_neighbors < i_nodes) ? i_neighbors : i_nodes;

    always_comb begin
        w_mask = '0;
        for (int j = 0; j < MAX_NODES; j++) begin
            w_mask[j] = (knn_pkg::CNT_W'(j) < i_nodes) && ({1'b0, r_rank[j]} < w_k);
        end
    end

    // Row of the closing beat, then the output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.close) begin
            r_close_row <= i_row;
        end
        if (i_cmd.load_out) begin
            r_out_row  <= r_close_row;
            r_out_mask <= w_mask;
        end
    end

    assign o_result_row    = r_out_row;
    assign o_neighbor_mask = r_out_mask;

endmodule

>>> rtl/k_nearest_neighbor_mask_core.sv
// A beat that does not close a row is taken while the controller is idle, one beat per cycle.
// The closing beat starts a sweep over the RAM, one stored distance per cycle, then a
// drain state and a finish state that loads the mask into the output register; input
// is held off from the closing beat until that load, longer while the previous mask
// still waits in the output register.
// Reset (synchronous, active low) clears control state and the register defaults.
module k_nearest_neighbor_mask_core #(
    parameter int MAX_NODES  = 64,
    parameter int DIST_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    knn_in_if.sink                             i_in,
    knn_out_if.source                          o_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [knn_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [knn_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [knn_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    logic [knn_pkg::CNT_W-1:0] w_neighbor_count;
    logic [knn_pkg::CNT_W-1:0] w_node_count;
    logic [knn_pkg::CNT_W-1:0] w_nodes;
    logic [knn_pkg::CNT_W-1:0] w_k;
    knn_pkg::t_dp_cmd          w_cmd;

    // Configuration registers.
    knn_cfg u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_prdata         (prdata),
        .o_pready         (pready),
        .o_neighbor_count (w_neighbor_count),
        .o_node_count     (w_node_count)
    );

    // Node count in use: zero acts as one, and it saturates at the store depth.
    always_comb begin
        if (w_node_count == '0) begin
            w_nodes = knn_pkg::CNT_W'(1);
        end else if (w_node_count > knn_pkg::CNT_W'(MAX_NODES)) begin
            w_nodes = knn_pkg::CNT_W'(MAX_NODES);
        end else begin
            w_nodes = w_node_count;
        end
    end

    assign w_k = (w_neighbor_count < w_nodes) ? w_neighbor_count : w_nodes;

    // Controller.
    knn_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_col       (i_in.column_index),
        .i_nodes     (w_nodes),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    // Datapath.
    knn_dpath #(
        .MAX_NODES  (MAX_NODES),
        .DIST_WIDTH (DIST_WIDTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_row           (i_in.row_index),
        .i_col           (i_in.column_index),
        .i_dist          (i_in.distance),
        .i_neighbors     (w_neighbor_count),
        .i_nodes         (w_nodes),
        .o_result_row    (o_out.result_row),
        .o_neighbor_mask (o_out.neighbor_mask)
    );

    // A closing beat starts a sweep, so no beat is taken in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.close |=> !i_in.ready)
        else $error("input accepted during ranking sweep");

    // Ranks are distinct, so a result marks exactly k columns.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ($countones(o_out.neighbor_mask) == int'(w_k)))
        else $error("neighbour mask does not mark k columns");

    // The output register is loaded only when it is free or being emptied.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out.valid || o_out.ready))
        else $error("pending result overwritten");

endmodule

>>> sim/k_nearest_neighbor_mask_core_test.sv
// Self-checking testbench for the k-nearest-neighbour mask core.
// Depends on knn_pkg, the stream interfaces in knn_if.sv and the core itself.
// Drives distance beats and APB writes; a scoreboard class predicts every neighbour mask.
module k_nearest_neighbor_mask_core_test;

    localparam int NODES         = 64;
    localparam int SETTLE_CYCLES = 80;
    localparam int TARGET_BEATS  = 1700;
    localparam int PHASE_BEATS   = 130;
    localparam int DRAIN_LIMIT   = 5000;

    typedef logic [knn_pkg::ROW_W-1:0]     t_row;
    typedef logic [knn_pkg::COL_W-1:0]     t_col;
    typedef logic [knn_pkg::IN_DIST_W-1:0] t_dist;
    typedef logic [knn_pkg::MASK_W-1:0]    t_mask;

    typedef struct packed {
        t_row  row;
        t_mask mask;
    } t_mask_beat;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    // Mirror of the distance store and registers, with the masks still owed by the core.
    class mask_scoreboard;
        t_dist                     distances[NODES];
        logic [NODES-1:0]          written;
        logic [knn_pkg::CNT_W-1:0] neighbor_count;
        logic [knn_pkg::CNT_W-1:0] node_count;
        t_mask_beat                expected_masks[$];
        int                        errors;

        function new();
            written        = '0;
            neighbor_count = knn_pkg::NEIGHBOR_COUNT_RST;
            node_count     = knn_pkg::NODE_COUNT_RST;
            errors         = 0;
        endfunction

        // A node count of zero behaves as one, and anything above the store size as full.
        function int active_nodes();
            if (node_count == 0) return 1;
            if (node_count > NODES) return NODES;
            return int'(node_count);
        endfunction

        function void set_register(logic index, logic [knn_pkg::CNT_W-1:0] value);
            if (index == knn_pkg::REG_NEIGHBOR_COUNT) neighbor_count = value;
            else node_count = value;
        endfunction

        // A row may only close once every active slot has held a distance; steer otherwise.
        function t_col safe_column(t_col col);
            int n;
            n = active_nodes();
            if (int'(col) != n - 1) return col;
            for (int i = 0; i < n - 1; i++)
                if (!written[i]) return t_col'(i);
            return col;
        endfunction

        // Store one accepted beat; the beat at the last active column ranks the row.
        function void note_distance(t_row row, t_col col, t_dist dist_val);
            int         n;
            int         k;
            int         rank;
            t_mask_beat beat;
            n = active_nodes();
            distances[col] = dist_val;
            written[col]   = 1'b1;
            if (int'(col) != n - 1) return;
            k = (int'(neighbor_count) < n) ? int'(neighbor_count) : n;
            beat.row  = row;
            beat.mask = '0;
            for (int j = 0; j < n; j++) begin
                rank = 0;
                // Equal distances rank the lower column first.
                for (int i = 0; i < n; i++)
                    if (i != j && (distances[i] < distances[j] ||
                                   (distances[i] == distances[j] && i < j)))
                        rank++;
                if (rank < k) beat.mask[j] = 1'b1;
            end
            expected_masks = {expected_masks, beat};
        endfunction

        function void check_mask(t_row row, t_mask mask);
            t_mask_beat exp_beat;
            if (expected_masks.size() == 0) begin
                $error("unexpected mask beat: result_row %0d, neighbor_mask %h", row, mask);
                errors++;
                return;
            end
            exp_beat = expected_masks.pop_front();
            if (row !== exp_beat.row) begin
                $error("result_row mismatch: expected %0d, actual %0d", exp_beat.row, row);
                errors++;
            end
            if (mask !== exp_beat.mask) begin
                $error("neighbor_mask mismatch: expected %h, actual %h", exp_beat.mask, mask);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [knn_pkg::APB_ADDR_W-1:0] paddr;
    logic [knn_pkg::APB_DATA_W-1:0] pwdata;
    logic [knn_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    knn_in_if  dist_ch ();
    knn_out_if mask_ch ();

    mask_scoreboard sb;
    t_idle_mode     idle_mode = IDLE_NONE;
    int             beats_sent = 0;

    k_nearest_neighbor_mask_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (dist_ch),
        .o_out   (mask_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver stalls at random in the stalling modes and is always ready otherwise.
    always @(negedge i_clk) begin
        case (idle_mode)
            IDLE_RECEIVER: begin
                mask_ch.ready <= ($urandom_range(0, 99) >= 47);
            end
            IDLE_BOTH: begin
                mask_ch.ready <= ($urandom_range(0, 99) >= 33);
            end
            default: begin
                mask_ch.ready <= 1'b1;
            end
        endcase
    end

    // Every accepted mask beat is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && mask_ch.valid && mask_ch.ready) begin
            sb.check_mask(mask_ch.result_row, mask_ch.neighbor_mask);
        end
    end

    function automatic bit sender_pause();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 47;
            IDLE_BOTH:   return $urandom_range(0, 99) < 33;
            default:     return 1'b0;
        endcase
    endfunction

    // Many full-range values, with plenty of small ones so that ties are common.
    function automatic t_dist random_distance();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return t_dist'($urandom_range(0, 7));
            5:       return t_dist'(1) << $urandom_range(0, knn_pkg::IN_DIST_W - 1);
            default: return t_dist'($urandom);
        endcase
    endfunction

    task automatic apb_access(input logic wr, input logic index,
                              input logic [knn_pkg::APB_DATA_W-1:0] wdata,
                              output logic [knn_pkg::APB_DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {index, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write a register and read it straight back.
    task automatic write_register(input logic index, input logic [knn_pkg::CNT_W-1:0] value);
        logic [knn_pkg::APB_DATA_W-1:0] rdata;
        apb_access(1'b1, index, knn_pkg::APB_DATA_W'(value), rdata);
        sb.set_register(index, value);
        apb_access(1'b0, index, '0, rdata);
        if (rdata !== knn_pkg::APB_DATA_W'(value)) begin
            $error("prdata mismatch: expected %h, actual %h",
                   knn_pkg::APB_DATA_W'(value), rdata);
            sb.errors++;
        end
    endtask

    // Lower valid and wait for every owed mask; optionally let the core settle as well.
    task automatic drain(input bit settle);
        @(negedge i_clk);
        dist_ch.valid <= 1'b0;
        while (sb.expected_masks.size() != 0) @(posedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [knn_pkg::CNT_W-1:0] k,
                             input logic [knn_pkg::CNT_W-1:0] n);
        drain(1'b1);
        write_register(knn_pkg::REG_NEIGHBOR_COUNT, k);
        write_register(knn_pkg::REG_NODE_COUNT, n);
    endtask

    task automatic send_distance(input t_row row, input t_col col, input t_dist dist_val);
        t_col safe_col;
        @(negedge i_clk);
        while (sender_pause()) begin
            dist_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        safe_col = sb.safe_column(col);
        dist_ch.valid        <= 1'b1;
        dist_ch.row_index    <= row;
        dist_ch.column_index <= safe_col;
        dist_ch.distance     <= dist_val;
        do @(posedge i_clk); while (!dist_ch.ready);
        sb.note_distance(row, safe_col, dist_val);
        beats_sent++;
    endtask

    // Columns 0 up to stop_at-1 in order under one row index; a full row closes.
    task automatic send_row(input int stop_at);
        t_row row;
        row = t_row'($urandom);
        for (int c = 0; c < stop_at; c++) send_distance(row, t_col'(c), random_distance());
    endtask

    // A row with skipped columns and the odd stray row index.
    task automatic send_scrambled_row(input int n);
        t_row row;
        row = t_row'($urandom);
        for (int c = 0; c < n; c++) begin
            if ($urandom_range(0, 4) != 0) begin
                send_distance(($urandom_range(0, 3) == 0) ? t_row'($urandom) : row,
                              t_col'(c), random_distance());
            end
        end
    endtask

    task automatic run_phase(input int k, input int n, input t_idle_mode mode);
        int n_eff;
        int start;
        int pause_at;
        int pick;
        configure(knn_pkg::CNT_W'(k), knn_pkg::CNT_W'(n));
        idle_mode = mode;
        n_eff     = sb.active_nodes();
        start     = beats_sent;
        pause_at  = $urandom_range(PHASE_BEATS / 4, 3 * PHASE_BEATS / 4);
        while (beats_sent - start < PHASE_BEATS) begin
            // Once per phase the sender holds back until the core has caught up.
            if (pause_at >= 0 && beats_sent - start >= pause_at) begin
                drain(1'b0);
                pause_at = -1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                send_row(n_eff);
            end else if (pick == 7) begin
                send_row($urandom_range(1, n_eff));
            end else if (pick == 8) begin
                send_scrambled_row(n_eff);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_distance(t_row'($urandom),
                                  $urandom_range(0, 1) ? t_col'($urandom_range(0, n_eff - 1))
                                                       : t_col'($urandom),
                                  random_distance());
                end
            end
        end
    endtask

    initial begin
        #4_000_000;
        $display("k_nearest_neighbor_mask_core_test: errors");
        $finish;
    end

    initial begin
        int node_list[14] = '{4, 64, 1, 8, 0, 3, 127, 12, 2, 100, 6, 5, 16, 7};
        int phase;
        int n;
        int n_eff;
        int k;
        int waited;

        sb = new();
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        dist_ch.valid        = 1'b0;
        dist_ch.row_index    = '0;
        dist_ch.column_index = '0;
        dist_ch.distance     = '0;
        mask_ch.ready        = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a zero neighbour count still emits an empty mask.
        configure(0, 1);
        send_distance(6'd63, 6'd0, '1);
        configure(1, 1);
        send_distance(6'd0, 6'd0, '0);
        // A node count of zero acts as one; a huge neighbour count marks everything.
        configure(127, 0);
        send_distance(6'd21, 6'd0, 32'h8000_0000);
        // Equal distances go to the lower column.
        configure(2, 4);
        send_distance(6'd5, 6'd0, 32'd7);
        send_distance(6'd5, 6'd1, 32'd3);
        send_distance(6'd5, 6'd2, 32'd3);
        send_distance(6'd5, 6'd3, 32'd0);
        // A column beyond the node count is stored but closes nothing.
        send_distance(6'd42, 6'd9, 32'd0);
        // Mixed row indexes: the closing beat names the row.
        send_distance(6'd6, 6'd0, '1);
        send_distance(6'd7, 6'd1, 32'd1);
        send_distance(6'd8, 6'd2, '1);
        send_distance(6'd9, 6'd3, 32'd2);
        // Out of order with column 1 left over from the previous row.
        send_distance(6'd10, 6'd2, 32'd0);
        send_distance(6'd10, 6'd0, 32'hFFFF_0000);
        send_distance(6'd10, 6'd3, 32'd1);
        // Neighbour count equal to node count, all distances tied.
        configure(4, 4);
        for (int c = 0; c < 4; c++) send_distance(6'd33, t_col'(c), 32'h0001_0000);

        // Random phases rotating through settings and idling modes.
        phase = 0;
        while (beats_sent < TARGET_BEATS) begin
            n     = (phase < 14) ? node_list[phase] : $urandom_range(1, 10);
            n_eff = (n == 0) ? 1 : ((n > NODES) ? NODES : n);
            case (phase % 7)
                0:       k = $urandom_range(0, n_eff);
                1:       k = 0;
                2:       k = n_eff;
                3:       k = 127;
                4:       k = 64;
                5:       k = 1;
                default: k = n_eff + 1;
            endcase
            run_phase(k, n, t_idle_mode'(phase % 4));
            phase++;
        end

        // Wait for the last masks, then give the core time to show any stray beat.
        @(negedge i_clk);
        dist_ch.valid <= 1'b0;
        waited = 0;
        while (sb.expected_masks.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (sb.expected_masks.size() != 0) begin
            $error("%0d neighbour masks never arrived", sb.expected_masks.size());
            sb.errors++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("k_nearest_neighbor_mask_core_test: clean");
        end else begin
            $display("k_nearest_neighbor_mask_core_test: errors");
        end
        $finish;
    end

endmodule
